### rtl/tcs_pkg.sv
package tcs_pkg;

    // Fixed field widths of the transaction payloads
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Actions
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Control bytes of the put action
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic [2:0] TAB_STEPS = 3'd5;

    typedef struct packed {
        logic [1:0]        action;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_tcs_in;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_tcs_out;

endpackage

### rtl/tcs_ram.sv
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_scroller.sv
// Text console of ROWS x COLUMNS cells (character byte, attribute byte) with a cursor,
// held in one RAM with one write and one registered read port. A transaction is taken
// only while the sequencer is idle. A scroll copies one cell per cycle, then blanks the
// bottom row; there is one scroll per wrap past the last row. After reset the block
// stalls its input while it zeroes the screen; attribute writes are taken meanwhile.
// A finished result waits in an output register, so the next transaction may be
// accepted while the consumer stalls.
module text_console_scroller #(
    parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcs_pkg::ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tcs_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  tcs_pkg::t_tcs_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output tcs_pkg::t_tcs_out         o_out_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int MRW   = (RW > tcs_pkg::ROW_W) ? RW : tcs_pkg::ROW_W;
    localparam int LW    = MRW + tcs_pkg::COL_W + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_CALC   = 4'd2;
    localparam logic [3:0] S_WRITE  = 4'd3;
    localparam logic [3:0] S_STEP   = 4'd4;
    localparam logic [3:0] S_SCROLL = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_FILL   = 4'd7;
    localparam logic [3:0] S_READ   = 4'd8;
    localparam logic [3:0] S_RDATA  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]                    r_state, n_state;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [CW-1:0]                 r_col, n_col;
    logic [RW-1:0]                 r_row, n_row;
    logic [tcs_pkg::ATTR_W-1:0]    r_attr;
    logic                          r_out_valid, n_out_valid;
    logic                          r_wr_pend, n_wr_pend;
    logic [2:0]                    r_steps, n_steps;
    logic                          r_force, n_force;

    tcs_pkg::t_tcs_in              r_in, n_in;
    tcs_pkg::t_tcs_out             r_out, n_out;
    logic [AW-1:0]                 r_lin, n_lin;
    logic                          r_in_range, n_in_range;
    logic [tcs_pkg::CELL_W-1:0]    r_cell, n_cell;
    logic [AW-1:0]                 r_wr_addr, n_wr_addr;
    logic [tcs_pkg::CELL_W-1:0]    r_fill_data, n_fill_data;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tcs_pkg::CELL_W-1:0]    ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [tcs_pkg::CELL_W-1:0]    ram_rdata;

    logic [MRW-1:0]                m_row;
    logic [tcs_pkg::COL_W-1:0]     m_col;
    logic [LW-1:0]                 lin_wide;
    logic                          wrap;
    logic                          last_row;

    tcs_ram #(
        .WIDTH (tcs_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Linear cell address: the read address on a read, else the cursor
    always_comb begin
        if (r_in.action == tcs_pkg::ACT_READ) begin
            m_row = MRW'(r_in.row);
            m_col = r_in.column;
        end else begin
            m_row = MRW'(r_row);
            m_col = tcs_pkg::COL_W'(r_col);
        end
        lin_wide = LW'(m_row) * LW'(COLUMNS) + LW'(m_col);
    end

    assign wrap     = r_force || (r_col == CW'(COLUMNS - 1));
    assign last_row = (r_row == RW'(ROWS - 1));

    // Write port: a pending scroll copy first, then fills, then a character
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_lin;
        ram_wdata = {r_in.char_code, r_attr};
        priority if (r_wr_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_wr_addr;
            ram_wdata = ram_rdata;
        end else if (r_state == S_INIT) begin
            ram_we    = 1'b1;
            ram_waddr = r_ptr;
            ram_wdata = '0;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_ptr;
            ram_wdata = r_fill_data;
        end else if (r_state == S_WRITE) begin
            ram_we    = 1'b1;
        end
    end

    assign ram_raddr = (r_state == S_SCROLL) ? r_ptr : r_lin;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        n_wr_pend   = 1'b0;
        n_steps     = r_steps;
        n_force     = r_force;
        n_in        = r_in;
        n_out       = r_out;
        n_lin       = r_lin;
        n_in_range  = r_in_range;
        n_cell      = r_cell;
        n_wr_addr   = r_wr_addr;
        n_fill_data = r_fill_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_cell  = '0;
                    n_state = S_CALC;
                end
            end
            S_INIT: begin
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_CALC: begin
                n_lin      = AW'(lin_wide);
                n_in_range = (r_in.column < COLUMNS) && (r_in.row < ROWS);
                n_state    = S_DONE;
                unique case (r_in.action)
                    tcs_pkg::ACT_PUT: begin
                        priority if (r_in.char_code == tcs_pkg::CH_NUL) begin
                            n_state = S_DONE;
                        end else if (r_in.char_code == tcs_pkg::CH_NL) begin
                            n_steps = 3'd1;
                            n_force = 1'b1;
                            n_state = S_STEP;
                        end else if (r_in.char_code == tcs_pkg::CH_TAB) begin
                            n_steps = tcs_pkg::TAB_STEPS;
                            n_force = 1'b0;
                            n_state = S_STEP;
                        end else if (r_in.char_code == tcs_pkg::CH_CR) begin
                            n_col   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                    tcs_pkg::ACT_CLEAR: begin
                        n_ptr       = '0;
                        n_fill_data = {tcs_pkg::CHAR_W'(0), r_attr};
                        n_state     = S_FILL;
                    end
                    tcs_pkg::ACT_SET: begin
                        n_col = (r_in.column < COLUMNS) ? CW'(r_in.column) : CW'(COLUMNS - 1);
                        n_row = (r_in.row < ROWS) ? RW'(r_in.row) : RW'(ROWS - 1);
                    end
                    tcs_pkg::ACT_READ: begin
                        n_state = S_READ;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WRITE: begin
                n_steps = 3'd1;
                n_force = 1'b0;
                n_state = S_STEP;
            end
            S_STEP: begin
                // Advance one cell; wrap past the last row scrolls and holds the row
                n_force = 1'b0;
                n_steps = r_steps - 3'd1;
                if (!wrap) begin
                    n_col = r_col + CW'(1);
                end else begin
                    n_col = '0;
                    if (!last_row) begin
                        n_row = r_row + RW'(1);
                    end
                end
                if (wrap && last_row) begin
                    n_ptr   = AW'(COLUMNS);
                    n_state = S_SCROLL;
                end else if (r_steps == 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                // Read one row below, write the data back in the following cycle
                n_wr_pend = 1'b1;
                n_wr_addr = r_ptr - AW'(COLUMNS);
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_DRAIN: begin
                n_ptr       = AW'(CELLS - COLUMNS);
                n_fill_data = {tcs_pkg::CHAR_W'(0), r_attr};
                n_state     = S_FILL;
            end
            S_FILL: begin
                if (r_ptr == AW'(CELLS - 1)) begin
                    if (r_in.action == tcs_pkg::ACT_CLEAR || r_steps == 3'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_cell  = r_in_range ? ram_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_char  = r_cell[tcs_pkg::CELL_W-1:tcs_pkg::ATTR_W];
                    n_out.cell_attr  = r_cell[tcs_pkg::ATTR_W-1:0];
                    n_out.cursor_col = tcs_pkg::COL_W'(r_col);
                    n_out.cursor_row = tcs_pkg::ROW_W'(r_row);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= tcs_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_steps     <= '0;
            r_force     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
            r_steps     <= n_steps;
            r_force     <= n_force;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_out       <= n_out;
        r_lin       <= n_lin;
        r_in_range  <= n_in_range;
        r_cell      <= n_cell;
        r_wr_addr   <= n_wr_addr;
        r_fill_data <= n_fill_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/tcs_checker.sv
module tcs_checker #(
    parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcs_pkg::ROWS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input tcs_pkg::t_tcs_out          o_out_data
);

    // Reset starts the screen clear, so input must stall right after
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // One transaction at a time: the sequencer is busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_col < COLUMNS) && (o_out_data.cursor_row < ROWS))
        else $error("cursor off screen");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind text_console_scroller tcs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcs_checker (.*);

### verif/text_console_scroller_tb.sv
module text_console_scroller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS        = tcs_pkg::COLUMNS_DEF;
    localparam int LINES       = tcs_pkg::ROWS_DEF;
    localparam int CELLS       = COLS * LINES;
    localparam int DRAIN_WAIT  = 2 * CELLS + 16;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [tcs_pkg::ATTR_W-1:0] i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    tcs_pkg::t_tcs_in           i_in_data = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    tcs_pkg::t_tcs_out          o_out_data;

    text_console_scroller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the console
    logic [tcs_pkg::CHAR_W-1:0] shadow_char [CELLS];
    logic [tcs_pkg::ATTR_W-1:0] shadow_attr [CELLS];
    int                         cur_col = 0;
    int                         cur_row = 0;
    logic [tcs_pkg::ATTR_W-1:0] attr_reg = tcs_pkg::ATTR_RESET;

    tcs_pkg::t_tcs_in  pending_items[$];
    tcs_pkg::t_tcs_out expected_reports[$];

    int sender_gap_pct = 0;
    int recv_stall_pct = 0;
    int items_accepted = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        for (int k = 0; k < CELLS; k++) begin
            shadow_char[k] = '0;
            shadow_attr[k] = '0;
        end
    end

    function automatic void advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= LINES) begin
            // scroll up one row, blank the bottom row
            for (int k = 0; k < CELLS - COLS; k++) begin
                shadow_char[k] = shadow_char[k + COLS];
                shadow_attr[k] = shadow_attr[k + COLS];
            end
            for (int k = CELLS - COLS; k < CELLS; k++) begin
                shadow_char[k] = tcs_pkg::CH_NUL;
                shadow_attr[k] = attr_reg;
            end
            cur_row = LINES - 1;
        end
    endfunction

    function automatic void advance_cell();
        cur_col++;
        if (cur_col >= COLS)
            advance_row();
    endfunction

    function automatic tcs_pkg::t_tcs_out console_apply(tcs_pkg::t_tcs_in item);
        tcs_pkg::t_tcs_out res;
        res = '0;
        case (item.action)
            tcs_pkg::ACT_PUT: begin
                case (item.char_code)
                    tcs_pkg::CH_NUL: ;
                    tcs_pkg::CH_NL: advance_row();
                    tcs_pkg::CH_TAB: begin
                        for (int k = 0; k < int'(tcs_pkg::TAB_STEPS); k++)
                            advance_cell();
                    end
                    tcs_pkg::CH_CR: cur_col = 0;
                    default: begin
                        shadow_char[cur_row * COLS + cur_col] = item.char_code;
                        shadow_attr[cur_row * COLS + cur_col] = attr_reg;
                        advance_cell();
                    end
                endcase
            end
            tcs_pkg::ACT_CLEAR: begin
                for (int k = 0; k < CELLS; k++) begin
                    shadow_char[k] = tcs_pkg::CH_NUL;
                    shadow_attr[k] = attr_reg;
                end
            end
            tcs_pkg::ACT_SET: begin
                cur_col = (int'(item.column) < COLS) ? int'(item.column) : COLS - 1;
                cur_row = (int'(item.row) < LINES) ? int'(item.row) : LINES - 1;
            end
            default: begin
                if (int'(item.column) < COLS && int'(item.row) < LINES) begin
                    res.cell_char = shadow_char[int'(item.row) * COLS + int'(item.column)];
                    res.cell_attr = shadow_attr[int'(item.row) * COLS + int'(item.column)];
                end
            end
        endcase
        res.cursor_col = tcs_pkg::COL_W'(cur_col);
        res.cursor_row = tcs_pkg::ROW_W'(cur_row);
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Mostly text with control bytes, some cursor moves, reads and rare clears
    function automatic tcs_pkg::t_tcs_in text_item();
        tcs_pkg::t_tcs_in it;
        int               pick;
        it.action    = tcs_pkg::ACT_PUT;
        it.char_code = tcs_pkg::CHAR_W'($urandom_range(255));
        it.column    = tcs_pkg::COL_W'($urandom_range(127));
        it.row       = tcs_pkg::ROW_W'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 5) begin
            it.char_code = tcs_pkg::CH_NL;
        end else if (pick < 9) begin
            it.char_code = tcs_pkg::CH_TAB;
        end else if (pick < 12) begin
            it.char_code = tcs_pkg::CH_CR;
        end else if (pick < 14) begin
            it.char_code = tcs_pkg::CH_NUL;
        end else if (pick < 20) begin
            it.action = tcs_pkg::ACT_SET;
            if ($urandom_range(1) == 1)
                it.row = tcs_pkg::ROW_W'($urandom_range(22, 31));
        end else if (pick < 29) begin
            it.action = tcs_pkg::ACT_READ;
            if ($urandom_range(1) == 1) begin
                it.row    = tcs_pkg::ROW_W'($urandom_range(18, LINES - 1));
                it.column = tcs_pkg::COL_W'($urandom_range(COLS - 1));
            end
        end else if (pick < 30) begin
            it.action = tcs_pkg::ACT_CLEAR;
        end else if ($urandom_range(3) != 0) begin
            it.char_code = tcs_pkg::CHAR_W'($urandom_range(32, 126));
        end
        return it;
    endfunction

    task automatic queue_item(logic [1:0] act, logic [tcs_pkg::CHAR_W-1:0] code,
                              logic [tcs_pkg::COL_W-1:0] col,
                              logic [tcs_pkg::ROW_W-1:0] row);
        tcs_pkg::t_tcs_in it;
        it.action    = act;
        it.char_code = code;
        it.column    = col;
        it.row       = row;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Driver: record accepted transactions, present the next pending one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_reports.push_back(console_apply(i_in_data));
                items_accepted <= items_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side so the block backs up
    always @(posedge i_clk) begin
        if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        tcs_pkg::t_tcs_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, o_out_data);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cell_char", want.cell_char, o_out_data.cell_char);
                    check_field("cell_attr", want.cell_attr, o_out_data.cell_attr);
                    check_field("cursor_col", 8'(want.cursor_col), 8'(o_out_data.cursor_col));
                    check_field("cursor_row", 8'(want.cursor_row), 8'(o_out_data.cursor_row));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_scroller_tb: errors");
            $finish;
        end
    end

    initial begin
        logic [tcs_pkg::ATTR_W-1:0] attr_value;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at the reset attribute
        queue_item(tcs_pkg::ACT_READ, 8'hFF, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, 8'h41, 7'd127, 5'd31);
        queue_item(tcs_pkg::ACT_PUT, 8'hFF, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, 8'h01, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_NUL, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_TAB, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_CR, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_NL, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'd1, 5'd0);
        queue_item(tcs_pkg::ACT_SET, 8'h00, 7'd127, 5'd31);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'd127, 5'd31);
        queue_item(tcs_pkg::ACT_PUT, 8'h5A, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'(COLS - 1), 5'(LINES - 2));
        queue_item(tcs_pkg::ACT_SET, 8'h00, 7'(COLS - 2), 5'(LINES - 1));
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_TAB, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_SET, 8'h00, 7'd0, 5'(LINES - 1));
        queue_item(tcs_pkg::ACT_PUT, tcs_pkg::CH_NL, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_CLEAR, 8'hFF, 7'd127, 5'd31);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'd0, 5'd0);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'(COLS - 1), 5'(LINES - 1));
        queue_item(tcs_pkg::ACT_SET, 8'h00, 7'(COLS), 5'd0);
        queue_item(tcs_pkg::ACT_SET, 8'h00, 7'd0, 5'(LINES));
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'(COLS), 5'd0);
        queue_item(tcs_pkg::ACT_READ, 8'h00, 7'd0, 5'(LINES));

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: attr_value = 8'h00;
                1: attr_value = 8'hFF;
                2: attr_value = tcs_pkg::ATTR_W'($urandom_range(255));
                default: attr_value = tcs_pkg::ATTR_W'($urandom_range(1, 254));
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= attr_value;
            attr_reg = attr_value;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            case (phase)
                0: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_gap_pct = 62; recv_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  recv_stall_pct = 62; end
                default: begin sender_gap_pct = 31; recv_stall_pct = 31; end
            endcase
            @(negedge i_clk);
            repeat (PHASE_ITEMS) pending_items.push_back(text_item());
        end

        wait_drained();
        if (error_count == 0)
            $display("text_console_scroller_tb: clean");
        else
            $display("text_console_scroller_tb: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/tcs_pkg.sv
rtl/tcs_ram.sv
rtl/text_console_scroller.sv
rtl/tcs_checker.sv
verif/text_console_scroller_tb.sv
